// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pit assertion failed");

// next-cycle implication, disabled while in reset
`define PIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pit assertion failed");

`endif

// ===== sv/pit_pkg.sv =====
// shared types and constants of the pending-interest table
package pit_pkg;

    // default sizes
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int FACE_COUNT_DEF  = 4;

    // home slot hashing: key bits folded per cycle
    localparam int KEY_W         = 32;
    localparam int BITS_PER_STEP = 4;
    localparam int HASH_STEPS    = KEY_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(HASH_STEPS);

    // request queue between front and back
    localparam int FIFO_DEPTH = 2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // one accepted request
    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] expiry;
        logic [1:0]  face;
    } pit_req_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE
    } back_state_t;

endpackage

// ===== sv/pit_hash_table_linear_probe.sv =====
// top level of the pending-interest table with linear probing
//
// Command interface: a request (opcode, key_print, expiry_time, face_number)
// is taken at a rising edge with start high and busy low. Each request gives
// exactly one result (status, slot_index), shown for one cycle with done high.
// The receiver cannot hold results off.
//
// The front computes the home slot, key modulo TABLE_SLOTS, four key bits a
// cycle, and hands the request to a two-entry queue. busy stays high after a
// transfer until the request is pushed, which waits while the queue is full.
// The back walks the table one slot a cycle through a ram with registered
// read; a request visits 1 to TABLE_SLOTS slots. The back pops the next one
// only from idle. With an empty queue, done rises after the hash, push, idle
// and probe states; the front can hash the next request meanwhile.
//
// After reset the back clears the table, one slot a cycle. Requests are still
// taken during that pass and wait in the queue.
module pit_hash_table_linear_probe #(
    parameter int TABLE_SLOTS = pit_pkg::TABLE_SLOTS_DEF,
    parameter int FACE_COUNT  = pit_pkg::FACE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] key_print,
    input  logic [31:0] expiry_time,
    input  logic [1:0]  face_number,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  slot_index
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int QW = $bits(pit_pkg::pit_req_t) + IW;
    localparam int RW = FACE_COUNT + 65;

    pit_pkg::pit_req_t req;
    pit_pkg::pit_req_t push_req;
    logic [IW-1:0]     push_home;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    logic [QW-1:0]     pop_data;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    logic [RW-1:0]     wdata;
    logic [RW-1:0]     rdata;

    // request bundle
    always_comb
    begin
        req.op     = opcode;
        req.key    = key_print;
        req.expiry = expiry_time;
        req.face   = face_number;
    end

    pit_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .push      (push),
        .push_req  (push_req),
        .push_home (push_home),
        .full      (full)
    );

    pit_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_req, push_home}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    pit_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .FACE_COUNT  (FACE_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .raddr      (raddr),
        .rdata      (rdata),
        .done       (done),
        .status     (status),
        .slot_index (slot_index)
    );

    // slot storage: valid, key, expiry, face mask
    pit_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

// ===== sv/pit_ram.sv =====
// generic single write port ram with registered read
module pit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pit_fifo.sv =====
// short request queue between the front and the back
`include "assert_macros.svh"

module pit_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(pit_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(pit_pkg::FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [pit_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(pit_pkg::FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(pit_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(pit_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // queue discipline
    `PIT_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
    `PIT_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !empty)

endmodule

// ===== sv/pit_front.sv =====
// front part: accepts requests and computes the home slot
module pit_front #(
    parameter int TABLE_SLOTS = pit_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pit_pkg::pit_req_t              req,
    output logic                           push,
    output pit_pkg::pit_req_t              push_req,
    output logic [$clog2(TABLE_SLOTS)-1:0] push_home,
    input  logic                           full
);

    localparam int IW  = $clog2(TABLE_SLOTS);
    localparam int IW1 = IW + 1;
    localparam logic [IW1-1:0] MOD = IW1'(TABLE_SLOTS);

    pit_pkg::front_state_t state_reg, state_next;

    pit_pkg::pit_req_t                  req_reg;
    logic [pit_pkg::KEY_W-1:0]          key_sh_reg, key_sh_next;
    logic [IW-1:0]                      rem_reg, rem_next;
    logic [pit_pkg::STEP_CNT_W-1:0]     step_reg, step_next;
    logic                               accept;
    logic                               last_step;

    assign accept    = start && (state_reg == pit_pkg::FR_IDLE);
    assign last_step = (step_reg == pit_pkg::STEP_CNT_W'(pit_pkg::HASH_STEPS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pit_pkg::FR_IDLE:
            begin
                if (start)
                begin
                    state_next = pit_pkg::FR_HASH;
                end
            end
            pit_pkg::FR_HASH:
            begin
                if (last_step)
                begin
                    state_next = pit_pkg::FR_PUSH;
                end
            end
            pit_pkg::FR_PUSH:
            begin
                if (!full)
                begin
                    state_next = pit_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = pit_pkg::FR_IDLE;
            end
        endcase
    end

    // remainder by the table size, a few key bits per cycle
    always_comb
    begin
        logic [IW1-1:0] t;
        t = IW1'(rem_reg);
        for (int b = 0; b < pit_pkg::BITS_PER_STEP; b++)
        begin
            t = {t[IW-1:0], key_sh_reg[pit_pkg::KEY_W-1-b]};
            if (t >= MOD)
            begin
                t = t - MOD;
            end
        end
        rem_next = t[IW-1:0];
    end

    // outputs and datapath control
    always_comb
    begin
        busy        = (state_reg != pit_pkg::FR_IDLE);
        push        = (state_reg == pit_pkg::FR_PUSH) && !full;
        push_req    = req_reg;
        push_home   = rem_reg;
        key_sh_next = key_sh_reg << pit_pkg::BITS_PER_STEP;
        step_next   = step_reg + 1'b1;
        case (state_reg)
            pit_pkg::FR_IDLE:
            begin
                key_sh_next = req.key;
                step_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pit_pkg::FR_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // request capture and hash datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            rem_reg <= '0;
        end
        else if (state_reg == pit_pkg::FR_HASH)
        begin
            rem_reg <= rem_next;
        end
        key_sh_reg <= key_sh_next;
    end

endmodule

// ===== sv/pit_back.sv =====
// back part: clears the table, probes slots and writes entries
`include "assert_macros.svh"

module pit_back #(
    parameter int TABLE_SLOTS = pit_pkg::TABLE_SLOTS_DEF,
    parameter int FACE_COUNT  = pit_pkg::FACE_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  empty,
    input  logic [$bits(pit_pkg::pit_req_t)+$clog2(TABLE_SLOTS)-1:0] pop_data,
    output logic                                  pop,
    output logic                                  we,
    output logic [$clog2(TABLE_SLOTS)-1:0]        waddr,
    output logic [FACE_COUNT+64:0]                wdata,
    output logic [$clog2(TABLE_SLOTS)-1:0]        raddr,
    input  logic [FACE_COUNT+64:0]                rdata,
    output logic                                  done,
    output logic [2:0]                            status,
    output logic [3:0]                            slot_index
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

    pit_pkg::back_state_t state_reg, state_next;

    pit_pkg::pit_req_t   cur_req_reg;
    pit_pkg::pit_req_t   head_req;
    logic [IW-1:0]       head_home;
    logic [IW-1:0]       issue_reg, issue_next;
    logic [IW-1:0]       eval_reg, eval_next;
    logic [IW-1:0]       count_reg, count_next;
    logic [IW-1:0]       clr_reg, clr_next;
    logic                done_reg, done_next;
    pit_pkg::status_t    status_reg, status_next;
    logic [3:0]          slot_reg, slot_next;

    logic                  s_valid;
    logic [31:0]           s_key;
    logic [31:0]           s_expiry;
    logic [FACE_COUNT-1:0] s_mask;
    logic [FACE_COUNT-1:0] face_bit;
    logic                  hit_empty;
    logic                  hit_match;
    logic                  finish;
    logic [31:0]           eval_wide;

    assign head_req  = pit_pkg::pit_req_t'(pop_data[$bits(pop_data)-1:IW]);
    assign head_home = pop_data[IW-1:0];

    // slot fields of the word read last cycle
    assign s_valid   = rdata[FACE_COUNT+64];
    assign s_key     = rdata[FACE_COUNT+63:FACE_COUNT+32];
    assign s_expiry  = rdata[FACE_COUNT+31:FACE_COUNT];
    assign s_mask    = rdata[FACE_COUNT-1:0];
    assign eval_wide = 32'(eval_reg);

    // one-hot face bit, empty when the face is out of range
    always_comb
    begin
        for (int i = 0; i < FACE_COUNT; i++)
        begin
            face_bit[i] = (32'(cur_req_reg.face) == i);
        end
    end

    assign hit_empty = !s_valid;
    assign hit_match = s_valid && (s_key == cur_req_reg.key);
    assign finish    = hit_empty || hit_match || (count_reg == LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pit_pkg::BK_CLEAR:
            begin
                if (clr_reg == LAST)
                begin
                    state_next = pit_pkg::BK_IDLE;
                end
            end
            pit_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = pit_pkg::BK_PROBE;
                end
            end
            pit_pkg::BK_PROBE:
            begin
                if (finish)
                begin
                    state_next = pit_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pit_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs: memory access, probe walk and result
    always_comb
    begin
        pop         = 1'b0;
        we          = 1'b0;
        waddr       = eval_reg;
        wdata       = '0;
        raddr       = issue_reg;
        issue_next  = issue_reg;
        eval_next   = eval_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        case (state_reg)
            pit_pkg::BK_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            pit_pkg::BK_IDLE:
            begin
                raddr = head_home;
                if (!empty)
                begin
                    pop        = 1'b1;
                    eval_next  = head_home;
                    issue_next = (head_home == LAST) ? '0 : head_home + 1'b1;
                    count_next = '0;
                end
            end
            pit_pkg::BK_PROBE:
            begin
                eval_next  = issue_reg;
                issue_next = (issue_reg == LAST) ? '0 : issue_reg + 1'b1;
                count_next = count_reg + 1'b1;
                if (hit_empty)
                begin
                    done_next = 1'b1;
                    if (cur_req_reg.op == pit_pkg::OP_SEARCH)
                    begin
                        status_next = pit_pkg::ST_NOT_FOUND;
                        slot_next   = '0;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata       = {1'b1, cur_req_reg.key, cur_req_reg.expiry, face_bit};
                        status_next = pit_pkg::ST_INSERTED;
                        slot_next   = eval_wide[3:0];
                    end
                end
                else if (hit_match)
                begin
                    done_next = 1'b1;
                    slot_next = eval_wide[3:0];
                    if (cur_req_reg.op == pit_pkg::OP_SEARCH)
                    begin
                        status_next = pit_pkg::ST_FOUND;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata       = {1'b1, s_key,
                                       (s_expiry < cur_req_reg.expiry) ?
                                           cur_req_reg.expiry : s_expiry,
                                       s_mask | face_bit};
                        status_next = pit_pkg::ST_UPDATED;
                    end
                end
                else if (count_reg == LAST)
                begin
                    done_next   = 1'b1;
                    slot_next   = '0;
                    status_next = (cur_req_reg.op == pit_pkg::OP_SEARCH) ?
                                  pit_pkg::ST_NOT_FOUND : pit_pkg::ST_FULL;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pit_pkg::BK_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            issue_reg <= '0;
            eval_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            eval_reg  <= eval_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_req_reg <= head_req;
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

    // a result only follows a probe decision
    `PIT_ASSERT_NXT(a_done_after_probe, clk, rst_n,
        (state_reg == pit_pkg::BK_PROBE) && finish, done_reg)
    `PIT_ASSERT_IMP(a_done_src, clk, rst_n,
        done_reg, $past(state_reg) == pit_pkg::BK_PROBE)

endmodule

// ===== dv/pit_hash_table_linear_probe_tb.sv =====
// testbench for the linear-probing pending-interest table with a built-in table predictor
`timescale 1ns / 100ps

module pit_hash_table_linear_probe_tb;

    localparam int SLOT_N      = pit_pkg::TABLE_SLOTS_DEF;
    localparam int FACE_N      = pit_pkg::FACE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    // one expected lookup outcome
    typedef struct packed {
        pit_pkg::status_t st;
        logic [3:0]       slot;
    } pit_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] key_print;
    logic [31:0] expiry_time;
    logic [1:0]  face_number;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  slot_index;

    // shadow copy of the table
    logic              tbl_valid [SLOT_N];
    logic [31:0]       tbl_key   [SLOT_N];
    logic [31:0]       tbl_expiry[SLOT_N];
    logic [FACE_N-1:0] tbl_mask  [SLOT_N];

    pit_result_t   pending_results[$];
    logic [31:0]   stored_keys[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    logic          no_idle;

    pit_hash_table_linear_probe u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key_print   (key_print),
        .expiry_time (expiry_time),
        .face_number (face_number),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // walk the shadow table the way the block does and apply the insert or merge
    function automatic pit_result_t pit_lookup(input logic op, input logic [31:0] key,
                                               input logic [31:0] expiry, input logic [1:0] face);
        pit_result_t       res;
        int                idx;
        logic [FACE_N-1:0] face_mask;
        face_mask = '0;
        if (int'(face) < FACE_N)
            face_mask[face] = 1'b1;
        idx = int'(key % SLOT_N);
        for (int n = 0; n < SLOT_N; n++)
        begin
            if (!tbl_valid[idx])
            begin
                if (op == pit_pkg::OP_SEARCH)
                begin
                    res.st   = pit_pkg::ST_NOT_FOUND;
                    res.slot = '0;
                    return res;
                end
                tbl_valid[idx]  = 1'b1;
                tbl_key[idx]    = key;
                tbl_expiry[idx] = expiry;
                tbl_mask[idx]   = face_mask;
                stored_keys.push_back(key);
                res.st   = pit_pkg::ST_INSERTED;
                res.slot = 4'(idx);
                return res;
            end
            if (tbl_key[idx] == key)
            begin
                if (op == pit_pkg::OP_SEARCH)
                begin
                    res.st   = pit_pkg::ST_FOUND;
                    res.slot = 4'(idx);
                    return res;
                end
                tbl_mask[idx] = tbl_mask[idx] | face_mask;
                if (tbl_expiry[idx] < expiry)
                    tbl_expiry[idx] = expiry;
                res.st   = pit_pkg::ST_UPDATED;
                res.slot = 4'(idx);
                return res;
            end
            idx = (idx + 1) % SLOT_N;
        end
        // every slot visited without a match
        res.st   = (op == pit_pkg::OP_SEARCH) ? pit_pkg::ST_NOT_FOUND : pit_pkg::ST_FULL;
        res.slot = '0;
        return res;
    endfunction

    // drive one request after a random gap and wait for its transfer
    task automatic send_request(input logic op, input logic [31:0] key,
                                input logic [31:0] expiry, input logic [1:0] face);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode      <= op;
        key_print   <= key;
        expiry_time <= expiry;
        face_number <= face;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(pit_lookup(op, key, expiry, face));
    endtask

    // searches on an empty table
    task automatic test_empty_search();
        send_request(pit_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(pit_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    endtask

    // keys sharing a home slot, then merges with larger and smaller expiry
    task automatic test_collide_and_merge();
        send_request(pit_pkg::OP_INSERT, 32'h0000_0003, 32'h0000_0010, 2'd0);
        send_request(pit_pkg::OP_INSERT, 32'h1000_0003, 32'h8000_0000, 2'd1);
        send_request(pit_pkg::OP_INSERT, 32'hFFFF_FFF3, 32'hFFFF_FFFF, 2'd2);
        send_request(pit_pkg::OP_INSERT, 32'h1000_0003, 32'h0000_0000, 2'd3);
        send_request(pit_pkg::OP_INSERT, 32'h0000_0003, 32'hFFFF_FFFF, 2'd0);
        send_request(pit_pkg::OP_SEARCH, 32'hFFFF_FFF3, 32'h0000_0000, 2'd1);
        send_request(pit_pkg::OP_SEARCH, 32'h2000_0003, 32'h1234_5678, 2'd2);
    endtask

    // probe walk wrapping from the last slot to the first
    task automatic test_wrap();
        send_request(pit_pkg::OP_INSERT, 32'h0000_000F, 32'h0000_0001, 2'd1);
        send_request(pit_pkg::OP_INSERT, 32'hABCD_EF0F, 32'h0000_0002, 2'd2);
        send_request(pit_pkg::OP_INSERT, 32'h1234_5600, 32'h0000_0003, 2'd3);
        send_request(pit_pkg::OP_SEARCH, 32'hABCD_EF0F, 32'h0000_0000, 2'd0);
    endtask

    // fill every slot, then insert and search an absent key on the full table and merge a stored one
    task automatic test_full_table();
        for (int i = 0; i < 10; i++)
            send_request(pit_pkg::OP_INSERT, 32'h8000_0002 + (i << 4), $urandom,
                         2'($urandom_range(0, 3)));
        send_request(pit_pkg::OP_INSERT, 32'h5555_5552, 32'hFFFF_FFFF, 2'd1);
        send_request(pit_pkg::OP_SEARCH, 32'hDEAD_BEE2, 32'h0000_0000, 2'd2);
        send_request(pit_pkg::OP_INSERT, 32'h8000_0092, 32'h0000_0000, 2'd3);
    endtask

    // random mix of stored keys and fresh keys with random fields
    task automatic test_random_traffic();
        logic [31:0] key;
        logic [31:0] expiry;
        int          pick;
        for (int i = 0; i < 1600; i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) < 6 && stored_keys.size() > 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else
                key = $urandom;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                expiry = 32'h0000_0000;
            else if (pick == 1)
                expiry = 32'hFFFF_FFFF;
            else
                expiry = $urandom;
            send_request(1'($urandom_range(0, 1)), key, expiry, 2'($urandom_range(0, 3)));
        end
        no_idle = 1'b0;
    endtask

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, slot_index %0d", status, slot_index);
                fail_count++;
            end
            else
            begin
                pit_result_t exp_res;
                exp_res = pending_results.pop_front();
                if (status !== exp_res.st)
                begin
                    $error("status mismatch: expected %0d, actual %0d", exp_res.st, status);
                    fail_count++;
                end
                if (slot_index !== exp_res.slot)
                begin
                    $error("slot_index mismatch: expected %0d, actual %0d",
                           exp_res.slot, slot_index);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // reset, tests in turn, drain and verdict
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = pit_pkg::OP_INSERT;
        key_print   = '0;
        expiry_time = '0;
        face_number = '0;
        no_idle     = 1'b0;
        for (int i = 0; i < SLOT_N; i++)
        begin
            tbl_valid[i]  = 1'b0;
            tbl_key[i]    = '0;
            tbl_expiry[i] = '0;
            tbl_mask[i]   = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_search();
        test_collide_and_merge();
        test_wrap();
        test_full_table();
        test_random_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pit_pkg.sv
sv/pit_ram.sv
sv/pit_fifo.sv
sv/pit_front.sv
sv/pit_back.sv
sv/pit_hash_table_linear_probe.sv
dv/pit_hash_table_linear_probe_tb.sv
